// File: rtl/core/gtfp_pkg.sv
// Shared types and constants for the GARCH(1,1) Student-t forecast path core.
// Used by every module in rtl/core. No dependencies.
package gtfp_pkg;

  localparam int WORD_W  = 32;
  localparam int FRAC    = 16;
  localparam int UWORD_W = WORD_W - 1;

  // Shared shift-add multiplier: A operand width, B operand width (one bit per cycle)
  localparam int MUL_A_W = 48;
  localparam int MUL_B_W = 32;
  localparam int MUL_P_W = MUL_A_W + MUL_B_W;

  // Restoring divider for rho
  localparam int DIV_N_W = 48;

  // Bit-pair square root
  localparam int SQ_RAD_W  = 64;
  localparam int SQ_ROOT_W = SQ_RAD_W / 2;

  localparam logic [UWORD_W-1:0] TWO_Q = UWORD_W'(2) << FRAC;
  localparam logic [UWORD_W-1:0] VMAX  = '1;
  localparam logic [WORD_W-1:0]  SMIN  = {1'b1, {(WORD_W-1){1'b0}}};
  localparam logic [WORD_W-1:0]  SMAX  = {1'b0, {(WORD_W-1){1'b1}}};

  typedef struct packed {
    logic                     first_step;
    logic [UWORD_W-1:0]       omega;
    logic [UWORD_W-1:0]       alpha;
    logic [UWORD_W-1:0]       beta;
    logic signed [WORD_W-1:0] mean_level;
    logic [UWORD_W-1:0]       dof;
    logic [UWORD_W-1:0]       h_start;
    logic signed [WORD_W-1:0] shock;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] forecast;
    logic [UWORD_W-1:0]       variance;
    logic                     invalid;
  } out_t;

endpackage

// File: rtl/core/gtfp_mul.sv
// Shift-add unsigned multiplier, one multiplier bit per cycle.
// Depends on gtfp_pkg for operand widths.
module gtfp_mul (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [gtfp_pkg::MUL_A_W-1:0]      a,
  input  logic [gtfp_pkg::MUL_B_W-1:0]      b,
  output logic                              done,
  output logic [gtfp_pkg::MUL_P_W-1:0]      prod
);
  localparam int CW = $clog2(gtfp_pkg::MUL_B_W);
  localparam logic [CW-1:0] LAST = CW'(gtfp_pkg::MUL_B_W - 1);

  logic [gtfp_pkg::MUL_P_W-1:0] acc_r;
  logic [gtfp_pkg::MUL_A_W-1:0] a_r;
  logic [CW-1:0]                cnt_r;
  logic                         busy_r;
  logic                         done_r;
  logic [gtfp_pkg::MUL_A_W:0]   sum;

  // add multiplicand into the upper MUL_A_W bits when the low bit is set
  always_comb begin
    sum = {1'b0, acc_r[gtfp_pkg::MUL_P_W-1:gtfp_pkg::MUL_B_W]}
        + (acc_r[0] ? {1'b0, a_r} : '0);
  end

  // advance one bit per cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        acc_r  <= {{gtfp_pkg::MUL_A_W{1'b0}}, b};
        a_r    <= a;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        acc_r <= {sum, acc_r[gtfp_pkg::MUL_B_W-1:1]};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign prod = acc_r;
endmodule

// File: rtl/core/gtfp_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on gtfp_pkg for widths.
module gtfp_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [gtfp_pkg::DIV_N_W-1:0]      dividend,
  input  logic [gtfp_pkg::UWORD_W-1:0]      divisor,
  output logic                              done,
  output logic [gtfp_pkg::DIV_N_W-1:0]      quot
);
  localparam int CW = $clog2(gtfp_pkg::DIV_N_W);
  localparam logic [CW-1:0] LAST = CW'(gtfp_pkg::DIV_N_W - 1);

  logic [gtfp_pkg::DIV_N_W-1:0] dq_r;
  logic [gtfp_pkg::UWORD_W-1:0] rem_r;
  logic [gtfp_pkg::UWORD_W-1:0] dvs_r;
  logic [CW-1:0]                cnt_r;
  logic                         busy_r;
  logic                         done_r;
  logic [gtfp_pkg::UWORD_W:0]   trial;
  logic [gtfp_pkg::UWORD_W:0]   diff;
  logic                         take;

  // trial subtract of the divisor from the shifted remainder
  always_comb begin
    trial = {rem_r, dq_r[gtfp_pkg::DIV_N_W-1]};
    diff  = trial - {1'b0, dvs_r};
    take  = (trial >= {1'b0, dvs_r});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        dq_r   <= dividend;
        dvs_r  <= divisor;
        rem_r  <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= take ? diff[gtfp_pkg::UWORD_W-1:0] : trial[gtfp_pkg::UWORD_W-1:0];
        dq_r  <= {dq_r[gtfp_pkg::DIV_N_W-2:0], take};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quot = dq_r;
endmodule

// File: rtl/core/gtfp_sqrt.sv
// Digit-by-digit integer square root, one radicand bit pair per cycle.
// Depends on gtfp_pkg for widths.
module gtfp_sqrt (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               start,
  input  logic [gtfp_pkg::SQ_RAD_W-1:0]      rad,
  output logic                               done,
  output logic [gtfp_pkg::SQ_ROOT_W-1:0]     root
);
  localparam int RW = gtfp_pkg::SQ_ROOT_W;
  localparam int CW = $clog2(RW);
  localparam logic [CW-1:0] LAST = CW'(RW - 1);

  logic [gtfp_pkg::SQ_RAD_W-1:0] rad_r;
  logic [RW:0]                   rem_r;
  logic [RW-1:0]                 root_r;
  logic [CW-1:0]                 cnt_r;
  logic                          busy_r;
  logic                          done_r;
  logic [RW+1:0]                 rem_s;
  logic [RW+1:0]                 trial;
  logic [RW+1:0]                 diff;
  logic                          take;

  // bring down two bits and test root*4+1
  always_comb begin
    rem_s = {rem_r[RW-1:0], rad_r[gtfp_pkg::SQ_RAD_W-1 -: 2]};
    trial = {root_r, 2'b01};
    diff  = rem_s - trial;
    take  = (rem_s >= trial);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rad_r  <= rad;
        rem_r  <= '0;
        root_r <= '0;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r  <= take ? diff[RW:0] : rem_s[RW:0];
        root_r <= {root_r[RW-2:0], take};
        rad_r  <= {rad_r[gtfp_pkg::SQ_RAD_W-3:0], 2'b00};
        cnt_r  <= cnt_r + 1'b1;
        if (cnt_r == LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign root = root_r;
endmodule

// File: rtl/core/garch_t_forecast_path_core.sv
// GARCH(1,1) Student-t forecast path: one horizon step per input word.
// Sequencer plus shared serial multiplier, divider and square root.
// Depends on gtfp_pkg, gtfp_mul, gtfp_div, gtfp_sqrt.
//
// Usage:
//  - Input channel in_valid/in_ready/in_data carries one step word. A word with
//    first_step set opens a draw and latches omega, alpha, beta, mean, dof and
//    h_start; the previous value is taken from the cfg register.
//  - cfg_we/cfg_wdata write last_observation at once; write it only while idle.
//  - Output channel out_valid/out_ready/out_data carries forecast, variance and
//    the invalid flag, one word per input word.
//  - Each word runs six serial operations in turn (five multiplies and one root)
//    between the sequencing states; a negative scale skips product and root,
//    and an opening word with nonzero dof runs the 48-bit rho division first.
//    One word is in work at a time; the shared bit-serial units set the rate.
//  - in_ready is high while the sequencer is idle, also while a finished word
//    waits in the output register. If the receiver stalls, the next word runs
//    to its end and then holds until the output register frees.
//  - Synchronous reset clears the sequencer, all path state and last_observation.
module garch_t_forecast_path_core (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  gtfp_pkg::in_t                     in_data,
  output logic                              out_valid,
  input  logic                              out_ready,
  output gtfp_pkg::out_t                    out_data,
  input  logic                              cfg_we,
  input  logic [gtfp_pkg::WORD_W-1:0]       cfg_wdata
);
  localparam int W  = gtfp_pkg::WORD_W;
  localparam int UW = gtfp_pkg::UWORD_W;
  localparam int AW = gtfp_pkg::MUL_A_W;
  localparam int BW = gtfp_pkg::MUL_B_W;
  localparam int PW = gtfp_pkg::MUL_P_W;
  localparam int F  = gtfp_pkg::FRAC;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_LD, S_SQ, S_AT, S_BT, S_HC, S_PR, S_RT, S_FC, S_Y, S_OUT
  } state_t;

  state_t             state_r;
  logic [W-1:0]       last_obs_r;
  logic [UW-1:0]      omega_r, alpha_r, beta_r, var_r;
  logic [W-1:0]       mean_r, rho_r, prev_r, shock_r, y_r;
  logic [63:0]        at_r;
  logic [W+33:0]      sp_r;
  logic               bad_r, neg_r;
  gtfp_pkg::out_t     out_r;
  logic               out_valid_r;

  logic               mul_start_r, div_start_r, sq_start_r;
  logic [AW-1:0]      mul_a_r;
  logic [BW-1:0]      mul_b_r;
  logic [gtfp_pkg::DIV_N_W-1:0]   div_n_r;
  logic [UW-1:0]                  div_d_r;
  logic [gtfp_pkg::SQ_RAD_W-1:0]  sq_rad_r;

  logic               mul_done, div_done, sq_done;
  logic [PW-1:0]      prod;
  logic [gtfp_pkg::DIV_N_W-1:0]   quot;
  logic [gtfp_pkg::SQ_ROOT_W-1:0] root;

  logic [W:0]         dev;
  logic [W-1:0]       adev;
  logic [64:0]        hsum;
  logic [W-1:0]       ashock;
  logic [W+33:0]      ysum;
  logic [UW-1:0]      nu_diff;
  logic               nu_low;

  gtfp_mul u_mul (
    .clk(clk), .rst_n(rst_n), .start(mul_start_r), .a(mul_a_r), .b(mul_b_r),
    .done(mul_done), .prod(prod)
  );

  gtfp_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start_r), .dividend(div_n_r),
    .divisor(div_d_r), .done(div_done), .quot(quot)
  );

  gtfp_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start_r), .rad(sq_rad_r),
    .done(sq_done), .root(root)
  );

  // datapath helpers
  always_comb begin
    dev     = {prev_r[W-1], prev_r} - {mean_r[W-1], mean_r};
    adev    = dev[W] ? W'(-dev) : dev[W-1:0];
    hsum    = {1'b0, at_r} + {17'b0, prod[63:F]} + {34'b0, omega_r};
    ashock  = shock_r[W-1] ? (~shock_r + 1'b1) : shock_r;
    ysum    = {{F{sp_r[W+33]}}, sp_r[W+33:F]} + {{34{mean_r[W-1]}}, mean_r};
    nu_low  = (in_data.dof < gtfp_pkg::TWO_Q);
    nu_diff = nu_low ? (gtfp_pkg::TWO_Q - in_data.dof) : (in_data.dof - gtfp_pkg::TWO_Q);
  end

  // sequence one step through the shared units
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      last_obs_r  <= '0;
      omega_r     <= '0;
      alpha_r     <= '0;
      beta_r      <= '0;
      var_r       <= '0;
      mean_r      <= '0;
      rho_r       <= '0;
      prev_r      <= '0;
      bad_r       <= 1'b0;
      out_valid_r <= 1'b0;
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      sq_start_r  <= 1'b0;
    end else begin
      mul_start_r <= 1'b0;
      div_start_r <= 1'b0;
      sq_start_r  <= 1'b0;
      if (cfg_we) begin
        last_obs_r <= cfg_wdata;
      end
      if (out_valid_r && out_ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            shock_r <= in_data.shock;
            bad_r   <= 1'b0;
            state_r <= S_LD;
            if (in_data.first_step) begin
              omega_r <= in_data.omega;
              alpha_r <= in_data.alpha;
              beta_r  <= in_data.beta;
              mean_r  <= in_data.mean_level;
              var_r   <= in_data.h_start;
              prev_r  <= last_obs_r;
              neg_r   <= nu_low;
              if (in_data.dof == '0) begin
                rho_r <= gtfp_pkg::SMIN;
                bad_r <= 1'b1;
              end else begin
                div_n_r     <= {1'b0, nu_diff, {F{1'b0}}};
                div_d_r     <= in_data.dof;
                div_start_r <= 1'b1;
                state_r     <= S_DIV;
              end
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            if (!neg_r) begin
              rho_r <= quot[W-1:0];
            end else if (quot > {{(gtfp_pkg::DIV_N_W-W){1'b0}}, gtfp_pkg::SMIN}) begin
              rho_r <= gtfp_pkg::SMIN;
              bad_r <= 1'b1;
            end else begin
              rho_r <= W'(~quot + 1'b1);
            end
            state_r <= S_LD;
          end
        end
        S_LD: begin
          // square of the deviation from the mean
          mul_a_r     <= {{(AW-W){1'b0}}, adev};
          mul_b_r     <= adev;
          mul_start_r <= 1'b1;
          state_r     <= S_SQ;
        end
        S_SQ: begin
          if (mul_done) begin
            mul_a_r     <= prod[63:F];
            mul_b_r     <= {1'b0, alpha_r};
            mul_start_r <= 1'b1;
            state_r     <= S_AT;
          end
        end
        S_AT: begin
          if (mul_done) begin
            at_r        <= prod[79:F];
            mul_a_r     <= {{(AW-UW){1'b0}}, var_r};
            mul_b_r     <= {1'b0, beta_r};
            mul_start_r <= 1'b1;
            state_r     <= S_BT;
          end
        end
        S_BT: begin
          // sum the variance terms, saturate
          if (mul_done) begin
            if (hsum > {34'b0, gtfp_pkg::VMAX}) begin
              var_r <= gtfp_pkg::VMAX;
              bad_r <= 1'b1;
            end else begin
              var_r <= hsum[UW-1:0];
            end
            state_r <= S_HC;
          end
        end
        S_HC: begin
          if (rho_r[W-1]) begin
            // negative scale: zero root, flag if the product is nonzero
            if (var_r != '0) begin
              bad_r <= 1'b1;
            end
            mul_a_r     <= '0;
            mul_b_r     <= ashock;
            mul_start_r <= 1'b1;
            state_r     <= S_FC;
          end else begin
            mul_a_r     <= {{(AW-UW){1'b0}}, var_r};
            mul_b_r     <= rho_r;
            mul_start_r <= 1'b1;
            state_r     <= S_PR;
          end
        end
        S_PR: begin
          if (mul_done) begin
            sq_rad_r   <= {prod[47:0], {F{1'b0}}};
            sq_start_r <= 1'b1;
            state_r    <= S_RT;
          end
        end
        S_RT: begin
          if (sq_done) begin
            mul_a_r     <= {{(AW-gtfp_pkg::SQ_ROOT_W){1'b0}}, root};
            mul_b_r     <= ashock;
            mul_start_r <= 1'b1;
            state_r     <= S_FC;
          end
        end
        S_FC: begin
          if (mul_done) begin
            sp_r    <= shock_r[W-1] ? (~{2'b0, prod[63:0]} + 1'b1) : {2'b0, prod[63:0]};
            state_r <= S_Y;
          end
        end
        S_Y: begin
          // add the mean, saturate to the signed word
          if (ysum[W+33] && !(&ysum[W+32:W-1])) begin
            y_r   <= gtfp_pkg::SMIN;
            bad_r <= 1'b1;
          end else if (!ysum[W+33] && (|ysum[W+32:W-1])) begin
            y_r   <= gtfp_pkg::SMAX;
            bad_r <= 1'b1;
          end else begin
            y_r <= ysum[W-1:0];
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          // hold until the output register frees
          if (!out_valid_r || out_ready) begin
            out_r.forecast <= y_r;
            out_r.variance <= var_r;
            out_r.invalid  <= bad_r;
            out_valid_r    <= 1'b1;
            prev_r         <= y_r;
            state_r        <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
endmodule

// File: rtl/core/gtfp_chk.sv
// Port-level checker for the forecast path core, attached by bind.
// Depends on gtfp_pkg for the output word type.
module gtfp_chk (
  input logic           clk,
  input logic           rst_n,
  input logic           in_valid,
  input logic           in_ready,
  input logic           out_valid,
  input logic           out_ready,
  input gtfp_pkg::out_t out_data
);
  // reset empties the output register
  a_rst_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // reset returns the sequencer to idle
  a_rst_rdy: assert property (@(posedge clk) !rst_n |=> in_ready)
    else $error("in_ready low after reset");

  // a stalled result word holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result word changed");

  // one word in work at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a word is in work");
endmodule

bind garch_t_forecast_path_core gtfp_chk u_gtfp_chk (.*);

// File: tb/sv/tb_garch_t_forecast_path_core.sv
`timescale 1ns / 100ps
// Self-checking testbench for garch_t_forecast_path_core: a GARCH(1,1) Student-t path predictor.
// Depends on gtfp_pkg and the core RTL; handshakes driven with random idling.
module tb_garch_t_forecast_path_core;

  logic            clk;
  logic            rst_n;
  logic            in_valid;
  logic            in_ready;
  gtfp_pkg::in_t   in_data;
  logic            out_valid;
  logic            out_ready;
  gtfp_pkg::out_t  out_data;
  logic            cfg_we;
  logic [31:0]     cfg_wdata;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 300;
  localparam int IN_W           = $bits(gtfp_pkg::in_t);

  garch_t_forecast_path_core u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  // Path state of the predictor
  longint  last_obs_q;
  bit [63:0] var_q, omega_q, alpha_q, beta_q;
  longint  prev_q, mean_q, rho_q;

  gtfp_pkg::out_t forecast_q[$];
  int      err_count = 0;
  int      words_sent;
  int      words_checked = 0;
  int      send_idle_pct;
  int      recv_idle_pct;
  int      quiet_cycles = 0;

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic bit [63:0] isqrt64(bit [63:0] x);
    bit [63:0] res = 0;
    bit [63:0] b = 64'h1 << 62;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= res + b) begin
        x -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  // Advance the path by one step and return the expected word
  function automatic gtfp_pkg::out_t garch_step(gtfp_pkg::in_t w);
    gtfp_pkg::out_t r;
    bit        bad = 0;
    longint    nu, num, d, p, y, root_s;
    bit [63:0] ad, sq, aterm, bterm, h, root;
    if (w.first_step) begin
      nu      = longint'(w.dof);
      omega_q = 64'(w.omega);
      alpha_q = 64'(w.alpha);
      beta_q  = 64'(w.beta);
      mean_q  = longint'(w.mean_level);
      if (nu == 0) begin
        rho_q = -(64'sd1 <<< 31);
        bad   = 1;
      end else begin
        num   = (nu - (64'sd2 <<< 16)) * 65536;
        rho_q = num / nu;
        if (rho_q > 64'sd2147483647) begin
          rho_q = 64'sd2147483647; bad = 1;
        end else if (rho_q < -64'sd2147483648) begin
          rho_q = -64'sd2147483648; bad = 1;
        end
      end
      var_q  = 64'(w.h_start);
      prev_q = last_obs_q;
    end
    // Variance update
    d     = prev_q - mean_q;
    ad    = (d < 0) ? 64'(-d) : 64'(d);
    sq    = (ad * ad) >> 16;
    aterm = alpha_q * (sq >> 16) + ((alpha_q * (sq & 64'hFFFF)) >> 16);
    bterm = (beta_q * var_q) >> 16;
    if (aterm > 64'h7FFF_FFFF || bterm > 64'h7FFF_FFFF) h = 64'h8000_0000;
    else h = aterm + bterm + omega_q;
    if (h > 64'h7FFF_FFFF) begin
      h = 64'h7FFF_FFFF; bad = 1;
    end
    // Scale and forecast
    p    = rho_q * longint'(h);
    root = 0;
    if (p < 0) bad = 1;
    else root = isqrt64(64'(p) << 16);
    root_s = longint'(root) * longint'(w.shock);
    y = mean_q + (root_s >>> 16);
    if (y > 64'sd2147483647) begin
      y = 64'sd2147483647; bad = 1;
    end else if (y < -64'sd2147483648) begin
      y = -64'sd2147483648; bad = 1;
    end
    var_q  = h;
    prev_q = y;
    r.forecast = y[31:0];
    r.variance = h[30:0];
    r.invalid  = bad;
    return r;
  endfunction

  task automatic report(string what, longint got, longint want);
    err_count++;
    $display("mismatch on word %0d: %s got %0h want %0h", words_checked, what, got, want);
  endtask

  // Send one word with a random lead gap; valid stays high after acceptance
  task automatic send_word(gtfp_pkg::in_t w);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    do @(negedge clk); while (!in_ready);
    @(posedge clk);
    forecast_q.push_back(garch_step(w));
    words_sent++;
  endtask

  // Drain outstanding words, then let the core settle
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (forecast_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_last_obs(logic [31:0] v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    last_obs_q = longint'(signed'(v));
  endtask

  function automatic gtfp_pkg::in_t rand_word();
    gtfp_pkg::in_t w;
    w = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom});
    return w;
  endfunction

  // Opening word with plausible market-like parameters
  function automatic gtfp_pkg::in_t open_word();
    gtfp_pkg::in_t w;
    w = rand_word();
    w.first_step = 1'b1;
    w.omega      = 31'($urandom_range(0, 65536));
    w.alpha      = 31'($urandom_range(0, 20000));
    w.beta       = 31'($urandom_range(30000, 62000));
    w.mean_level = $signed($urandom_range(0, 20 << 16)) - (10 << 16);
    w.dof        = 31'($urandom_range(131073, 40 << 16));
    w.h_start    = 31'($urandom_range(0, 4 << 16));
    w.shock      = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
    return w;
  endfunction

  // Release the result channel at random
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Compare every accepted result against the oldest prediction
  always @(posedge clk) begin
    gtfp_pkg::out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (forecast_q.size() == 0) begin
        report("unexpected word", longint'(out_data), 0);
      end else begin
        want = forecast_q.pop_front();
        if (out_data.forecast !== want.forecast)
          report("forecast", longint'(out_data.forecast), longint'(want.forecast));
        if (out_data.variance !== want.variance)
          report("variance", longint'(out_data.variance), longint'(want.variance));
        if (out_data.invalid !== want.invalid)
          report("invalid", longint'(out_data.invalid), longint'(want.invalid));
      end
      words_checked++;
    end
  end

  // Watchdog on handshake activity
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  task automatic test_directed();
    gtfp_pkg::in_t w;
    // Continue before any opening: zero state
    w = rand_word(); w.first_step = 1'b0;
    send_word(w);
    write_last_obs(32'h7FFF_FFFF);
    // Zero dof
    w = open_word(); w.dof = '0;
    send_word(w);
    w.first_step = 1'b0;
    send_word(w);
    // Dof below two, saturated and not
    w = open_word(); w.dof = 31'd1;
    send_word(w);
    w = open_word(); w.dof = 31'd100000;
    send_word(w);
    // Negative rho times variance on continuation
    w.first_step = 1'b0; w.shock = 32'sh0001_0000;
    send_word(w);
    // Smallest legal dof, largest fields
    w = open_word(); w.dof = 31'd131073;
    send_word(w);
    w = '1;
    send_word(w);
    w.first_step = 1'b0;
    send_word(w);
    write_last_obs(32'h8000_0000);
    w = '0; w.first_step = 1'b1; w.dof = '1; w.mean_level = 32'sh7FFF_FFFF;
    w.shock = 32'sh8000_0000; w.h_start = '1; w.alpha = '1;
    send_word(w);
    w = open_word(); w.mean_level = 32'sh8000_0000; w.shock = 32'sh7FFF_FFFF;
    send_word(w);
    w.first_step = 1'b0;
    send_word(w);
    w = '0; w.first_step = 1'b1;
    send_word(w);
    write_last_obs(32'h0000_0000);
    w = open_word();
    send_word(w);
  endtask

  task automatic test_random(int sidle, int ridle, logic [31:0] obs, int n_words);
    gtfp_pkg::in_t w;
    int  len;
    write_last_obs(obs);
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    while (n_words > 0) begin
      if ($urandom_range(9) == 0) begin
        send_word(rand_word());
        n_words--;
      end else begin
        w = open_word();
        send_word(w);
        len = $urandom_range(1, 15);
        for (int i = 0; i < len; i++) begin
          w = rand_word();
          w.first_step = 1'b0;
          if ($urandom_range(3) != 0) w.shock = $signed($urandom_range(0, 8 << 16)) - (4 << 16);
          send_word(w);
        end
        n_words -= len + 1;
      end
    end
  endtask

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data       = '0;
    cfg_we        = 1'b0;
    cfg_wdata     = '0;
    words_sent    = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    last_obs_q    = 0;
    var_q = 0; omega_q = 0; alpha_q = 0; beta_q = 0;
    prev_q = 0; mean_q = 0; rho_q = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    test_random(0, 0, 32'h0001_8000, 200);
    test_random(74, 0, 32'hFFF0_0000, 200);
    test_random(0, 74, $urandom, 200);
    test_random(12, 12, 32'h0000_0000, 200);
    wait_idle();

    $display("covered %0d words, %0d results checked", words_sent, words_checked);
    $display("draw openings, zero and sub-two dof, saturation, four idling phases");
    if (err_count == 0 && forecast_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// File: garch_t_forecast_path_core.f
rtl/core/gtfp_pkg.sv
rtl/core/gtfp_mul.sv
rtl/core/gtfp_div.sv
rtl/core/gtfp_sqrt.sv
rtl/core/garch_t_forecast_path_core.sv
rtl/core/gtfp_chk.sv
tb/sv/tb_garch_t_forecast_path_core.sv
